FILE: hw/rtl/column_variance_correlation_accumulator_defines.svh
// Assertion macros for the column variance and correlation accumulator.
// Used by the checker only; expects signals named clk and rst in scope.
`ifndef COLUMN_VARIANCE_CORRELATION_ACCUMULATOR_DEFINES_SVH
`define COLUMN_VARIANCE_CORRELATION_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define CVCA_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CVCA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/cvca_pkg.sv
// Shared types and constants for the column variance and correlation accumulator.
// No dependencies.
package cvca_pkg;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int COUNT_BITS_DEF = 24;
  localparam int VALUE_BITS_DEF = 16;

  localparam int COL_W      = 10;
  localparam int CC_W       = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 16;
  localparam int SAMPLE_W   = 24;
  localparam int VAR_W      = 31;
  localparam int SD_W       = 16;
  localparam int CORR_W     = 16;
  localparam int DIV_W      = 64;
  localparam int DEN_W      = 32;
  localparam int SQRT_IN_W  = 32;

  // output word layout, lowest bit up
  localparam int OUT_CNT_LSB  = COL_W;
  localparam int OUT_VAR_LSB  = OUT_CNT_LSB + SAMPLE_W;
  localparam int OUT_SD_LSB   = OUT_VAR_LSB + VAR_W;
  localparam int OUT_CORR_LSB = OUT_SD_LSB + SD_W;
  localparam int OUT_DATA_W   = ((OUT_CORR_LSB + CORR_W + 7) / 8) * 8;
  localparam int USER_W       = 2;

  localparam logic MODE_ACC    = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_COUNT = 2'd0,
    CFG_REF_ENABLE   = 2'd1,
    CFG_REF_COLUMN   = 2'd2,
    CFG_ZERO_THR     = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_ACC, ST_LOAD, ST_MEAN, ST_MSQ, ST_QM, ST_VAR,
    ST_ROOT, ST_SQRT, ST_NEXT, ST_PM, ST_MP, ST_COV, ST_DIFF, ST_QSTART,
    ST_QWAIT, ST_OUT
  } state_t;

endpackage

FILE: hw/rtl/column_variance_correlation_accumulator.sv
// Per-column count, sum, sum of squares and reference-product sum held in one
// column memory; report words give variance, standard deviation and Pearson
// correlation. Depends on cvca_pkg, cvca_ram, cvca_div and cvca_sqrt.
//
// Each accumulate word is a read of the column entry, then the write back on
// the same memory port; no new word is taken until the write back. A report
// runs the serial divider twice and the square root once per column pass, and
// the divider twice more when a correlation is worked out. After reset the
// memory is cleared one entry a cycle, all MAX_COLS entries (1024 at default),
// with no word accepted.
module column_variance_correlation_accumulator #(
  parameter int MAX_COLS   = cvca_pkg::MAX_COLS_DEF,
  parameter int COUNT_BITS = cvca_pkg::COUNT_BITS_DEF,
  parameter int VALUE_BITS = cvca_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // column, value, ref_sample (lowest bit up), zero padded
  input  logic [((cvca_pkg::COL_W + 2*VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // mode, ref_valid
  input  logic [cvca_pkg::USER_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // report_column, sample_count, variance, std_dev, correlation, zero padded
  output logic [cvca_pkg::OUT_DATA_W-1:0] m_tdata,
  // has_data, var_nonzero
  output logic [cvca_pkg::USER_W-1:0] m_tuser,
  input  logic cfg_we,
  input  logic [cvca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cvca_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DIV_W  = cvca_pkg::DIV_W;
  localparam int DEN_W  = cvca_pkg::DEN_W;
  localparam int AW     = $clog2(MAX_COLS);
  localparam int CNT_W  = COUNT_BITS;
  localparam int VSUM_W = VALUE_BITS + COUNT_BITS;
  localparam int SSUM_W = (2*VALUE_BITS + COUNT_BITS > DIV_W) ? DIV_W
                          : 2*VALUE_BITS + COUNT_BITS;
  localparam int PSUM_W = (2*VALUE_BITS + COUNT_BITS + 1 > DIV_W) ? DIV_W
                          : 2*VALUE_BITS + COUNT_BITS + 1;
  localparam int OFF_VS = CNT_W;
  localparam int OFF_SS = OFF_VS + VSUM_W;
  localparam int OFF_PS = OFF_SS + SSUM_W;
  localparam int ENT_W  = OFF_PS + PSUM_W;
  localparam int MEAN_W = VALUE_BITS + 8;
  localparam int MSQ_W  = 2 * MEAN_W;
  localparam int V      = VALUE_BITS;
  localparam int COL_W  = cvca_pkg::COL_W;
  localparam int CMP_W  = 13;
  localparam int VAR_W  = cvca_pkg::VAR_W;
  localparam int SD_W   = cvca_pkg::SD_W;
  localparam int CORR_W = cvca_pkg::CORR_W;

  localparam logic [CMP_W-1:0] MAX_COLS_V = CMP_W'(MAX_COLS);
  localparam logic [CNT_W-1:0] CNT_LIMIT  = {CNT_W{1'b1}};

  // configuration
  logic [cvca_pkg::CC_W-1:0]  column_count;
  logic                       ref_enable;
  logic [COL_W-1:0]           ref_column;
  logic [cvca_pkg::THR_W-1:0] zero_thr;

  cvca_pkg::state_t state, state_next;
  logic             pass;
  logic [AW-1:0]    clr_addr;

  // memory port
  logic             mem_en, mem_we;
  logic [AW-1:0]    mem_addr;
  logic [ENT_W-1:0] mem_wdata, mem_rdata;

  // divider and root
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             sqrt_start, sqrt_done;
  logic [SD_W-1:0]  sqrt_root;

  // input fields
  logic             in_mode, in_ref_valid;
  logic [COL_W-1:0] in_col;
  logic signed [V-1:0] in_val, in_ref;
  logic [CMP_W-1:0] in_col_x, ref_col_x, active;
  logic             ref_ok;

  // held word
  logic [COL_W-1:0]        i_col;
  logic signed [V-1:0]     i_val;
  logic [2*V-1:0]          sq_r;
  logic signed [2*V-1:0]   pr_r;
  logic                    prod_en, acc_go;

  // entry read back
  logic [CNT_W-1:0]  rd_cnt;
  logic [VSUM_W-1:0] rd_vsum;
  logic [SSUM_W-1:0] rd_ssum;
  logic [PSUM_W-1:0] rd_psum;
  logic signed [DIV_W-1:0] vs_ext, vsh;
  logic [DIV_W-1:0]  mean_num;
  logic              load_more;

  // working stats of the column in hand
  logic [CNT_W-1:0]  w_n;
  logic [SSUM_W-1:0] w_ss;
  logic              w_vneg, w_mneg;
  logic [MEAN_W-1:0] w_mm;
  logic [MSQ_W-1:0]  msq_prod;
  logic [DIV_W-1:0]  w_msq, w_qm, var_d;
  logic [MSQ_W:0]    msq_rnd;
  logic [VAR_W-1:0]  w_var;
  logic [SD_W-1:0]   w_sd;
  logic              w_hv;

  // stats of the reported column
  logic [CNT_W-1:0]  n_c;
  logic [PSUM_W-1:0] psum_c;
  logic [MEAN_W-1:0] mm_c;
  logic              mneg_c;
  logic [VAR_W-1:0]  var_c;
  logic [SD_W-1:0]   sd_c;
  logic              hv_c;
  logic signed [CORR_W-1:0] corr_r;

  // correlation path
  logic signed [DIV_W-1:0] ps_ext;
  logic [DIV_W-1:0]   ps_mag;
  logic [CNT_W-1:0]   m_min;
  logic               is_ref, corr_go;
  logic [DIV_W-1:0]   pm_mag;
  logic [MSQ_W-1:0]   mp_prod;
  logic [MSQ_W:0]     mp_rnd;
  logic [MSQ_W-16:0]  mps_mag;
  logic signed [DIV_W:0]   pm_s;
  logic signed [DIV_W+1:0] diff, ndiff;
  logic [DIV_W:0]     cm;
  logic               c_neg, q_ovf;
  logic [DEN_W-1:0]   den_r;

  // output register
  logic [COL_W-1:0]    o_col;
  logic [cvca_pkg::SAMPLE_W-1:0] o_cnt;
  logic                o_hd, o_hv;
  logic [VAR_W-1:0]    o_var;
  logic [SD_W-1:0]     o_sd;
  logic [CORR_W-1:0]   o_corr;
  logic                out_load;

  assign in_mode      = s_tuser[0];
  assign in_ref_valid = s_tuser[1];
  assign in_col       = s_tdata[COL_W-1:0];
  assign in_val       = s_tdata[COL_W +: V];
  assign in_ref       = s_tdata[COL_W+V +: V];
  assign in_col_x     = CMP_W'(in_col);
  assign ref_col_x    = CMP_W'(ref_column);
  assign active       = (CMP_W'(column_count) < MAX_COLS_V) ? CMP_W'(column_count)
                                                           : MAX_COLS_V;
  assign ref_ok       = ref_enable && (ref_col_x < active);
  assign s_tready     = state == cvca_pkg::ST_IDLE;

  assign rd_cnt  = mem_rdata[CNT_W-1:0];
  assign rd_vsum = mem_rdata[OFF_VS +: VSUM_W];
  assign rd_ssum = mem_rdata[OFF_SS +: SSUM_W];
  assign rd_psum = mem_rdata[OFF_PS +: PSUM_W];
  assign vs_ext  = DIV_W'(signed'(rd_vsum));
  assign vsh     = vs_ext <<< 8;
  assign mean_num  = vsh[DIV_W-1] ? DIV_W'(-vsh) : DIV_W'(vsh);
  assign load_more = rd_cnt > CNT_W'(1);

  assign msq_rnd = {1'b0, msq_prod} + (MSQ_W+1)'(32768);
  assign var_d   = w_qm - w_msq;

  assign ps_ext  = DIV_W'(signed'(psum_c));
  assign ps_mag  = ps_ext[DIV_W-1] ? DIV_W'(-ps_ext) : DIV_W'(ps_ext);
  assign m_min   = (n_c < w_n) ? n_c : w_n;
  assign is_ref  = i_col == ref_column;
  assign corr_go = w_hv && !is_ref && hv_c;
  assign mp_rnd  = {1'b0, mp_prod} + (MSQ_W+1)'(32768);
  assign ndiff   = -diff;
  assign cm      = diff[DIV_W+1] ? ndiff[DIV_W:0] : diff[DIV_W:0];
  // difference would not fit the numerator once shifted by 15
  assign q_ovf   = |cm[DIV_W:DIV_W-15];

  assign out_load = (state == cvca_pkg::ST_OUT) && (!m_tvalid || m_tready);

  cvca_ram #(.WIDTH(ENT_W), .DEPTH(MAX_COLS)) u_ram (
    .clk(clk), .en(mem_en), .we(mem_we), .addr(mem_addr),
    .wdata(mem_wdata), .rdata(mem_rdata)
  );

  cvca_div #(.NUM_W(DIV_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  cvca_sqrt #(.IN_W(cvca_pkg::SQRT_IN_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start),
    .x(cvca_pkg::SQRT_IN_W'(w_var)), .done(sqrt_done), .root(sqrt_root)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= cvca_pkg::CC_W'(1024);
      ref_enable   <= 1'b0;
      ref_column   <= '0;
      zero_thr     <= '0;
    end else if (cfg_we) begin
      unique case (cvca_pkg::cfg_idx_t'(cfg_index))
        cvca_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data[cvca_pkg::CC_W-1:0];
        cvca_pkg::CFG_REF_ENABLE:   ref_enable   <= cfg_data[0];
        cvca_pkg::CFG_REF_COLUMN:   ref_column   <= cfg_data[COL_W-1:0];
        cvca_pkg::CFG_ZERO_THR:     zero_thr     <= cfg_data[cvca_pkg::THR_W-1:0];
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cvca_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(MAX_COLS - 1)) state_next = cvca_pkg::ST_IDLE;
      end
      cvca_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (in_mode == cvca_pkg::MODE_ACC) state_next = cvca_pkg::ST_ACC;
          else if (in_col_x < MAX_COLS_V)    state_next = cvca_pkg::ST_LOAD;
          else                               state_next = cvca_pkg::ST_OUT;
        end
      end
      cvca_pkg::ST_ACC:  state_next = cvca_pkg::ST_IDLE;
      cvca_pkg::ST_LOAD: state_next = load_more ? cvca_pkg::ST_MEAN : cvca_pkg::ST_OUT;
      cvca_pkg::ST_MEAN: if (div_done) state_next = cvca_pkg::ST_MSQ;
      cvca_pkg::ST_MSQ:  state_next = cvca_pkg::ST_QM;
      cvca_pkg::ST_QM:   if (div_done) state_next = cvca_pkg::ST_VAR;
      cvca_pkg::ST_VAR:  state_next = cvca_pkg::ST_ROOT;
      cvca_pkg::ST_ROOT: state_next = cvca_pkg::ST_SQRT;
      cvca_pkg::ST_SQRT: if (sqrt_done) state_next = cvca_pkg::ST_NEXT;
      cvca_pkg::ST_NEXT: begin
        if (!pass) state_next = ref_ok ? cvca_pkg::ST_LOAD : cvca_pkg::ST_OUT;
        else       state_next = corr_go ? cvca_pkg::ST_PM : cvca_pkg::ST_OUT;
      end
      cvca_pkg::ST_PM:   if (div_done) state_next = cvca_pkg::ST_MP;
      cvca_pkg::ST_MP:   state_next = cvca_pkg::ST_COV;
      cvca_pkg::ST_COV:  state_next = cvca_pkg::ST_DIFF;
      cvca_pkg::ST_DIFF: state_next = cvca_pkg::ST_QSTART;
      cvca_pkg::ST_QSTART: begin
        if (den_r == '0 || q_ovf) state_next = cvca_pkg::ST_OUT;
        else                      state_next = cvca_pkg::ST_QWAIT;
      end
      cvca_pkg::ST_QWAIT: if (div_done) state_next = cvca_pkg::ST_OUT;
      cvca_pkg::ST_OUT:   if (!m_tvalid || m_tready) state_next = cvca_pkg::ST_IDLE;
      default:            state_next = cvca_pkg::ST_IDLE;
    endcase
  end

  // memory, divider and root control
  always_comb begin
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = i_col[AW-1:0];
    mem_wdata  = '0;
    div_start  = 1'b0;
    div_num    = mean_num;
    div_den    = DEN_W'(rd_cnt);
    sqrt_start = 1'b0;
    unique case (state)
      cvca_pkg::ST_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      cvca_pkg::ST_IDLE: begin
        mem_en   = s_tvalid;
        mem_addr = in_col_x[AW-1:0];
      end
      cvca_pkg::ST_ACC: begin
        // a saturated count drops the word entirely
        mem_en    = acc_go && (rd_cnt != CNT_LIMIT);
        mem_we    = mem_en;
        mem_wdata = {rd_psum + (prod_en ? PSUM_W'(pr_r) : PSUM_W'(0)),
                     rd_ssum + SSUM_W'(sq_r),
                     rd_vsum + VSUM_W'(i_val),
                     rd_cnt + CNT_W'(1)};
      end
      cvca_pkg::ST_LOAD: div_start = load_more;
      cvca_pkg::ST_MSQ: begin
        div_start = 1'b1;
        div_num   = DIV_W'(w_ss);
        div_den   = DEN_W'(w_n);
      end
      cvca_pkg::ST_ROOT: sqrt_start = 1'b1;
      cvca_pkg::ST_NEXT: begin
        mem_en    = !pass && ref_ok;
        mem_addr  = ref_col_x[AW-1:0];
        div_start = pass && corr_go;
        div_num   = ps_mag;
        div_den   = DEN_W'(m_min);
      end
      cvca_pkg::ST_QSTART: begin
        div_start = (den_r != '0) && !q_ovf;
        div_num   = {cm[DIV_W-16:0], 15'b0};
        div_den   = den_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cvca_pkg::ST_CLEAR;
      clr_addr <= '0;
      pass     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cvca_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == cvca_pkg::ST_IDLE) pass <= 1'b0;
      else if (state == cvca_pkg::ST_NEXT && !pass && ref_ok) pass <= 1'b1;
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      cvca_pkg::ST_IDLE: begin
        i_col   <= in_col;
        i_val   <= in_val;
        sq_r    <= (2*V)'(in_val * in_val);
        pr_r    <= in_val * in_ref;
        prod_en <= ref_enable && in_ref_valid && (in_col != ref_column);
        acc_go  <= in_col_x < active;
        n_c     <= '0;
        var_c   <= '0;
        sd_c    <= '0;
        hv_c    <= 1'b0;
        corr_r  <= '0;
      end
      cvca_pkg::ST_LOAD: begin
        w_n    <= rd_cnt;
        w_ss   <= rd_ssum;
        w_vneg <= vsh[DIV_W-1];
        if (!pass) begin
          n_c    <= rd_cnt;
          psum_c <= rd_psum;
        end
      end
      cvca_pkg::ST_MEAN: begin
        w_mm   <= div_quo[MEAN_W-1:0];
        w_mneg <= w_vneg && (div_quo != '0);
      end
      cvca_pkg::ST_MSQ: msq_prod <= w_mm * w_mm;
      cvca_pkg::ST_QM: begin
        // settles long before the divider finishes
        w_msq <= DIV_W'(msq_rnd >> 16);
        w_qm  <= div_quo;
      end
      cvca_pkg::ST_VAR: begin
        if (w_qm <= w_msq)                 w_var <= '0;
        else if (var_d > DIV_W'({VAR_W{1'b1}})) w_var <= {VAR_W{1'b1}};
        else                               w_var <= var_d[VAR_W-1:0];
      end
      cvca_pkg::ST_ROOT: w_hv <= w_var > VAR_W'(zero_thr);
      cvca_pkg::ST_SQRT: w_sd <= sqrt_root;
      cvca_pkg::ST_NEXT: begin
        if (!pass) begin
          mm_c   <= w_mm;
          mneg_c <= w_mneg;
          var_c  <= w_var;
          sd_c   <= w_sd;
          hv_c   <= w_hv;
        end else if (w_hv && is_ref) begin
          corr_r <= {1'b0, {(CORR_W-1){1'b1}}};
        end
      end
      cvca_pkg::ST_PM:  pm_mag  <= div_quo;
      cvca_pkg::ST_MP:  mp_prod <= mm_c * w_mm;
      cvca_pkg::ST_COV: begin
        mps_mag <= mp_rnd[MSQ_W:16];
        pm_s    <= ps_ext[DIV_W-1] ? -signed'({1'b0, pm_mag}) : signed'({1'b0, pm_mag});
        den_r   <= DEN_W'(sd_c * w_sd);
      end
      cvca_pkg::ST_DIFF: begin
        if (mneg_c ^ w_mneg) diff <= (DIV_W+2)'(pm_s) + (DIV_W+2)'(mps_mag);
        else                 diff <= (DIV_W+2)'(pm_s) - (DIV_W+2)'(mps_mag);
      end
      cvca_pkg::ST_QSTART: begin
        c_neg <= diff[DIV_W+1];
        if (den_r != '0 && q_ovf) begin
          corr_r <= diff[DIV_W+1] ? {1'b1, {(CORR_W-1){1'b0}}}
                                  : {1'b0, {(CORR_W-1){1'b1}}};
        end
      end
      cvca_pkg::ST_QWAIT: begin
        if (c_neg) begin
          corr_r <= (div_quo >= DIV_W'(32768)) ? {1'b1, {(CORR_W-1){1'b0}}}
                                               : -signed'(div_quo[CORR_W-1:0]);
        end else begin
          corr_r <= (div_quo >= DIV_W'(32767)) ? {1'b0, {(CORR_W-1){1'b1}}}
                                               : signed'(div_quo[CORR_W-1:0]);
        end
      end
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_col  <= i_col;
      o_cnt  <= (32'(n_c) > 32'(24'hFFFFFF)) ? {cvca_pkg::SAMPLE_W{1'b1}}
                                             : cvca_pkg::SAMPLE_W'(n_c);
      o_hd   <= n_c > CNT_W'(1);
      o_var  <= var_c;
      o_sd   <= sd_c;
      o_hv   <= hv_c;
      o_corr <= corr_r;
    end
  end

  assign m_tdata = cvca_pkg::OUT_DATA_W'({o_corr, o_sd, o_var, o_cnt, o_col});
  assign m_tuser = {o_hv, o_hd};

endmodule

FILE: hw/rtl/cvca_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module cvca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hw/rtl/cvca_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module cvca_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, q[NUM_W-1]};
  assign ge    = trial >= {1'b0, d};
  assign diff  = trial - {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      q   <= {q[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/cvca_sqrt.sv
// Integer square root, two radicand bits per cycle, floor result.
// No dependencies.
module cvca_sqrt #(
  parameter int IN_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   x,
  output logic              done,
  output logic [IN_W/2-1:0] root
);

  localparam int H  = IN_W / 2;
  localparam int CW = $clog2(H + 1);

  logic [CW-1:0]   cnt;
  logic            busy;
  logic [IN_W-1:0] xs;
  logic [H-1:0]    rem;
  logic [H+1:0]    cand;
  logic [H+1:0]    trial;
  logic            ge;
  logic [H+1:0]    left;

  assign cand  = {rem, xs[IN_W-1:IN_W-2]};
  assign trial = {root, 2'b01};
  assign ge    = cand >= trial;
  assign left  = cand - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(H);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs   <= {xs[IN_W-3:0], 2'b00};
      rem  <= ge ? left[H-1:0] : cand[H-1:0];
      root <= {root[H-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/cvca_checker.sv
// Port-level checks on report words of the accumulator, bound to the top level.
// Depends on cvca_pkg and column_variance_correlation_accumulator_defines.svh.
`include "column_variance_correlation_accumulator_defines.svh"

module cvca_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cvca_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [cvca_pkg::USER_W-1:0]     m_tuser
);

  logic [cvca_pkg::VAR_W-1:0] var_f;
  logic [cvca_pkg::SD_W-1:0]  sd_f;
  logic [cvca_pkg::CORR_W-1:0] corr_f;

  assign var_f  = m_tdata[cvca_pkg::OUT_VAR_LSB +: cvca_pkg::VAR_W];
  assign sd_f   = m_tdata[cvca_pkg::OUT_SD_LSB +: cvca_pkg::SD_W];
  assign corr_f = m_tdata[cvca_pkg::OUT_CORR_LSB +: cvca_pkg::CORR_W];

  `CVCA_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "report word dropped")
  `CVCA_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "stalled word changed")
  `CVCA_ASSERT_NOW(a_hv_needs_data, m_tvalid && m_tuser[1], m_tuser[0], "variance without data")
  `CVCA_ASSERT_NOW(a_no_data_zero, m_tvalid && !m_tuser[0], var_f == '0 && sd_f == '0 && corr_f == '0, "statistics without data")
  `CVCA_ASSERT_NOW(a_root_zero, m_tvalid, (var_f == '0) == (sd_f == '0), "root disagrees with variance")

endmodule

bind column_variance_correlation_accumulator cvca_checker u_cvca_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: sim/column_variance_correlation_accumulator_test.sv
// Self-checking testbench for column_variance_correlation_accumulator.
// Random streams of field and report words are checked against a built-in predictor;
// depends on cvca_pkg and the block itself.
`timescale 1ns / 1ps

module column_variance_correlation_accumulator_test;

  typedef struct {
    logic        mode;
    logic [9:0]  column;
    logic [15:0] value;
    logic [15:0] ref_sample;
    logic        ref_valid;
  } field_word_t;

  typedef struct {
    logic [9:0]  column;
    logic [23:0] count;
    logic        has_data;
    logic [30:0] variance;
    logic [15:0] std_dev;
    logic        var_nonzero;
    logic [15:0] correlation;
  } report_t;

  typedef struct {
    longint unsigned n;
    longint unsigned var_q;
    longint unsigned sd;
    bit              hv;
    longint          mean;
  } col_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic [cvca_pkg::USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [cvca_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [cvca_pkg::USER_W-1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [cvca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cvca_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  column_variance_correlation_accumulator dut (.*);

  always #1 clk = ~clk;

  // predictor state
  longint unsigned value_acc [1024];
  longint unsigned square_acc [1024];
  longint unsigned product_acc [1024];
  longint unsigned field_cnt [1024];
  longint unsigned col_limit = 1024;
  bit              ref_on = 0;
  longint unsigned ref_col = 0;
  longint unsigned var_floor = 0;

  field_word_t pending [$];
  report_t     reports_due [$];
  int          errors = 0;
  int unsigned cyc = 0;

  function automatic longint unsigned mag(longint a);
    return a < 0 ? 64'd0 - longint'(a) : a;
  endfunction

  function automatic longint div_tz(longint a, longint unsigned n);
    longint unsigned q;
    q = mag(a) / n;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned used_cols();
    return col_limit < 1024 ? col_limit : 1024;
  endfunction

  function automatic col_stats_t column_stats(int c);
    col_stats_t s;
    longint unsigned mm, msq, qm;
    s = '{0, 0, 0, 0, 0};
    s.n = field_cnt[c];
    if (s.n <= 1) return s;
    s.mean = div_tz(longint'(value_acc[c] << 8), s.n);
    mm = mag(s.mean);
    msq = (mm * mm + 64'h8000) >> 16;
    qm = square_acc[c] / s.n;
    s.var_q = qm > msq ? qm - msq : 0;
    if (s.var_q > 64'h7FFFFFFF) s.var_q = 64'h7FFFFFFF;
    s.sd = int_sqrt(s.var_q);
    s.hv = s.var_q > var_floor;
    return s;
  endfunction

  function automatic longint pearson(int c, col_stats_t sc);
    col_stats_t sr;
    longint unsigned m, mp, den, cm, q;
    longint pm, mps, diff;
    if (!ref_on || ref_col >= used_cols()) return 0;
    sr = column_stats(int'(ref_col));
    if (!sr.hv) return 0;
    if (c == ref_col) return 32767;
    if (!sc.hv) return 0;
    m = sc.n < sr.n ? sc.n : sr.n;
    pm = div_tz(longint'(product_acc[c]), m);
    mp = (mag(sc.mean) * mag(sr.mean) + 64'h8000) >> 16;
    mps = ((sc.mean < 0) != (sr.mean < 0)) ? -longint'(mp) : longint'(mp);
    diff = pm - mps;
    cm = mag(diff);
    den = sc.sd * sr.sd;
    if (den == 0) return 0;
    q = (cm > (64'hFFFF_FFFF_FFFF_FFFF >> 15)) ? 64'hFFFF_FFFF_FFFF_FFFF : (cm << 15) / den;
    if (diff < 0) return q >= 32768 ? -32768 : -longint'(q);
    return q >= 32767 ? 32767 : longint'(q);
  endfunction

  task automatic absorb_word(field_word_t w);
    longint v, rv;
    col_stats_t s;
    report_t r;
    longint corr;
    int c;
    c = w.column;
    if (w.mode == cvca_pkg::MODE_ACC) begin
      if (c >= used_cols() || field_cnt[c] >= 64'hFFFFFF) return;
      v = longint'($signed(w.value));
      value_acc[c] += v;
      square_acc[c] += v * v;
      field_cnt[c]++;
      if (ref_on && w.ref_valid && c != ref_col) begin
        rv = longint'($signed(w.ref_sample));
        product_acc[c] += v * rv;
      end
      return;
    end
    s = column_stats(c);
    corr = s.n > 1 ? pearson(c, s) : 0;
    r.column = w.column;
    r.count = s.n > 64'hFFFFFF ? 24'hFFFFFF : s.n[23:0];
    r.has_data = s.n > 1;
    r.variance = s.var_q[30:0];
    r.std_dev = s.sd[15:0];
    r.var_nonzero = s.hv;
    r.correlation = corr[15:0];
    reports_due.push_back(r);
  endtask

  // sender: bursts with random gaps
  field_word_t held;
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_word(held);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          held = pending.pop_front();
          s_tdata <= {6'd0, held.ref_sample, held.value, held.column};
          s_tuser <= {held.ref_valid, held.mode};
          s_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: free-running stretches alternate with random stalls
  always @(posedge clk) begin
    cyc <= cyc + 1;
    m_tready <= cyc[10] ? 1'b1 : ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    report_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (reports_due.size() == 0) begin
        $error("report word with nothing expected");
        errors++;
      end else begin
        e = reports_due.pop_front();
        if (m_tdata[9:0] !== e.column) begin
          $error("report_column exp %0d got %0d", e.column, m_tdata[9:0]); errors++;
        end
        if (m_tdata[cvca_pkg::OUT_CNT_LSB +: cvca_pkg::SAMPLE_W] !== e.count) begin
          $error("sample_count exp %0d got %0d", e.count,
                 m_tdata[cvca_pkg::OUT_CNT_LSB +: cvca_pkg::SAMPLE_W]);
          errors++;
        end
        if (m_tuser[0] !== e.has_data) begin
          $error("has_data exp %0d got %0d", e.has_data, m_tuser[0]); errors++;
        end
        if (m_tdata[cvca_pkg::OUT_VAR_LSB +: cvca_pkg::VAR_W] !== e.variance) begin
          $error("variance exp %0d got %0d", e.variance,
                 m_tdata[cvca_pkg::OUT_VAR_LSB +: cvca_pkg::VAR_W]);
          errors++;
        end
        if (m_tdata[cvca_pkg::OUT_SD_LSB +: cvca_pkg::SD_W] !== e.std_dev) begin
          $error("std_dev exp %0d got %0d", e.std_dev,
                 m_tdata[cvca_pkg::OUT_SD_LSB +: cvca_pkg::SD_W]);
          errors++;
        end
        if (m_tuser[1] !== e.var_nonzero) begin
          $error("var_nonzero exp %0d got %0d", e.var_nonzero, m_tuser[1]); errors++;
        end
        if (m_tdata[cvca_pkg::OUT_CORR_LSB +: cvca_pkg::CORR_W] !== e.correlation) begin
          $error("correlation exp %0d got %0d", $signed(e.correlation),
                 $signed(m_tdata[cvca_pkg::OUT_CORR_LSB +: cvca_pkg::CORR_W]));
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cvca_pkg::cfg_idx_t idx, logic [15:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      cvca_pkg::CFG_COLUMN_COUNT: col_limit = d[10:0];
      cvca_pkg::CFG_REF_ENABLE:   ref_on = d[0];
      cvca_pkg::CFG_REF_COLUMN:   ref_col = d[9:0];
      cvca_pkg::CFG_ZERO_THR:     var_floor = d;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int cc, bit en, int rc, int thr);
    write_reg(cvca_pkg::CFG_COLUMN_COUNT, 16'(cc));
    write_reg(cvca_pkg::CFG_REF_ENABLE, 16'(en));
    write_reg(cvca_pkg::CFG_REF_COLUMN, 16'(rc));
    write_reg(cvca_pkg::CFG_ZERO_THR, 16'(thr));
  endtask

  task automatic queue_word(bit mode, int col, int v, int rv, bit ok);
    field_word_t w;
    w.mode = mode;
    w.column = 10'(col);
    w.value = 16'(v);
    w.ref_sample = 16'(rv);
    w.ref_valid = ok;
    pending.push_back(w);
  endtask

  task automatic queue_random(int n, int rc);
    int k, col, v, rv, pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      col = pick < 7 ? $urandom_range(0, 7) : (pick == 7 ? rc : $urandom_range(0, 1023));
      rv = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 4095) - 2048;
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = rv;
        2: v = -(rv / 2) + $urandom_range(0, 63) - 32;
        default: v = $urandom_range(0, 1023) - 512;
      endcase
      if (col == rc) v = rv;
      queue_word($urandom_range(0, 99) < 12, col, v, rv, $urandom_range(0, 7) != 0);
    end
  endtask

  // drain: every report back, then the block's own latency
  task automatic settle();
    while (pending.size() != 0 || s_tvalid || reports_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    configure(16, 1, 0, 0);
    // empty column, single sample, extremes, no reference, out-of-range columns
    queue_word(cvca_pkg::MODE_REPORT, 5, 0, 0, 0);
    queue_word(cvca_pkg::MODE_ACC, 5, 16'h7FFF, 0, 1);
    queue_word(cvca_pkg::MODE_REPORT, 5, 0, 0, 0);
    queue_word(cvca_pkg::MODE_ACC, 0, 16'h7FFF, 16'h7FFF, 1);
    queue_word(cvca_pkg::MODE_ACC, 0, 16'h8000, 16'h8000, 1);
    queue_word(cvca_pkg::MODE_ACC, 1, 16'h8000, 16'h8000, 1);
    queue_word(cvca_pkg::MODE_ACC, 1, 16'h7FFF, 16'h7FFF, 1);
    queue_word(cvca_pkg::MODE_ACC, 1, 16'h0100, 16'h0200, 0);
    queue_word(cvca_pkg::MODE_ACC, 2, 16'h0300, 16'h7FFF, 1);
    queue_word(cvca_pkg::MODE_ACC, 2, 16'h0300, 16'h8000, 1);
    queue_word(cvca_pkg::MODE_ACC, 3, 16'hFF00, 16'h7FFF, 1);
    queue_word(cvca_pkg::MODE_ACC, 3, 16'h0100, 16'h8000, 1);
    queue_word(cvca_pkg::MODE_ACC, 20, 16'h1234, 16'h1234, 1);
    queue_word(cvca_pkg::MODE_ACC, 1023, 16'h4321, 16'h1234, 1);
    queue_word(cvca_pkg::MODE_REPORT, 0, 16'hFFFF, 16'hFFFF, 1);
    queue_word(cvca_pkg::MODE_REPORT, 1, 0, 0, 0);
    queue_word(cvca_pkg::MODE_REPORT, 2, 0, 0, 0);
    queue_word(cvca_pkg::MODE_REPORT, 3, 0, 0, 0);
    queue_word(cvca_pkg::MODE_REPORT, 20, 0, 0, 0);
    queue_word(cvca_pkg::MODE_REPORT, 1023, 0, 0, 0);
    settle();
    queue_random(200, 0);
    settle();
    configure(1024, 1, 3, 100);
    queue_random(220, 3);
    settle();
    configure(1, 1, 0, 65535);
    queue_random(150, 0);
    settle();
    configure(8, 1, 12, 0);
    queue_random(150, 12);
    settle();
    configure(1024, 0, 1023, 0);
    queue_random(200, 1023);
    settle();
    configure(1024, 1, 1023, 16);
    queue_random(200, 1023);
    settle();
    configure(6, 1, 4, 2000);
    queue_random(150, 4);
    settle();
    if (errors == 0) begin
      $display("column_variance_correlation_accumulator_test passed");
    end else begin
      $display("column_variance_correlation_accumulator_test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("column_variance_correlation_accumulator_test failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/cvca_pkg.sv
hw/rtl/cvca_ram.sv
hw/rtl/cvca_div.sv
hw/rtl/cvca_sqrt.sv
hw/rtl/column_variance_correlation_accumulator.sv
hw/rtl/cvca_checker.sv
sim/column_variance_correlation_accumulator_test.sv
